>>> sv/tam_pkg.sv
// Shared types, constants and term helpers for the TRS to affine matrix block.
package tam_pkg;

  localparam int unsigned TransW = 32;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned ProdW  = 2 * QuatW;
  localparam int unsigned TermW  = ProdW + 3;
  localparam int unsigned WideW  = TermW + ScaleW;
  localparam int unsigned EntryW = 32;
  localparam int unsigned RndSh  = 14;
  localparam int unsigned NumEnt = 9;

  typedef logic signed [TransW-1:0] trans_t;
  typedef logic signed [QuatW-1:0]  quat_t;
  typedef logic signed [ScaleW-1:0] scale_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic signed [EntryW-1:0] entry_t;

  // 1.0 in the Q.28 product format
  localparam term_t OneQ28 = term_t'(64'sd1 <<< 28);

  // Load enables for the two stages held in each entry unit.
  typedef struct packed {
    logic s3;
    logic s4;
  } stage_en_t;

  function automatic term_t twice_sum(prod_t a, prod_t b);
    term_t s;
    s = term_t'(a) + term_t'(b);
    return s <<< 1;
  endfunction

  function automatic term_t twice_diff(prod_t a, prod_t b);
    term_t s;
    s = term_t'(a) - term_t'(b);
    return s <<< 1;
  endfunction

  function automatic term_t one_minus(prod_t a, prod_t b);
    return OneQ28 - twice_sum(a, b);
  endfunction

endpackage

>>> sv/trs_to_affine_matrix_top.sv
// Top level: quaternion, scale and translation to a 3x4 affine matrix, fixed point.
//
// Accepts one transform item per clock while in_tready is high and returns one
// result item per item, in order. The four register stages are: the nine
// 16x16 quaternion products, the bracketed Q.28 terms, the 35x16 scale
// multiply, and round-to-Q10.22 with saturation into the output register.
// Backpressure stalls only the run of full stages next to the output; a stage with an
// empty stage ahead keeps moving, so in_tready is low only while all four stages hold items.
module trs_to_affine_matrix_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tx, in_ty, in_tz, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // m_c0r0, m_c0r1, m_c0r2, m_c1r0, m_c1r1, m_c1r2, m_c2r0, m_c2r1, m_c2r2,
  // out_tx, out_ty, out_tz
  output logic [383:0] out_tdata
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  tam_pkg::trans_t tin [3];
  tam_pkg::quat_t  qx, qy, qz, qw;
  tam_pkg::scale_t sin [3];

  tam_pkg::prod_t  xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  tam_pkg::trans_t t1_r [3];
  tam_pkg::trans_t t2_r [3];
  tam_pkg::trans_t t3_r [3];
  tam_pkg::trans_t t4_r [3];
  tam_pkg::scale_t s1_r [3];
  tam_pkg::scale_t s2_r [3];
  tam_pkg::term_t  term_nxt [tam_pkg::NumEnt];
  tam_pkg::term_t  term_r   [tam_pkg::NumEnt];
  tam_pkg::entry_t ent      [tam_pkg::NumEnt];
  tam_pkg::stage_en_t en;

  // Unpack the input item.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tin[k] = in_tdata[32*k +: 32];
      sin[k] = in_tdata[160 + 16*k +: 16];
    end
    qx = in_tdata[111:96];
    qy = in_tdata[127:112];
    qz = in_tdata[143:128];
    qw = in_tdata[159:144];
  end

  // Stage ready: load when empty or when the item ahead moves on.
  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign v1_nxt = rdy1 ? in_tvalid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Stage 1: pairwise quaternion products.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      xx_r <= tam_pkg::prod_t'(qx) * tam_pkg::prod_t'(qx);
      yy_r <= tam_pkg::prod_t'(qy) * tam_pkg::prod_t'(qy);
      zz_r <= tam_pkg::prod_t'(qz) * tam_pkg::prod_t'(qz);
      xy_r <= tam_pkg::prod_t'(qx) * tam_pkg::prod_t'(qy);
      xz_r <= tam_pkg::prod_t'(qx) * tam_pkg::prod_t'(qz);
      yz_r <= tam_pkg::prod_t'(qy) * tam_pkg::prod_t'(qz);
      wx_r <= tam_pkg::prod_t'(qw) * tam_pkg::prod_t'(qx);
      wy_r <= tam_pkg::prod_t'(qw) * tam_pkg::prod_t'(qy);
      wz_r <= tam_pkg::prod_t'(qw) * tam_pkg::prod_t'(qz);
      t1_r <= tin;
      s1_r <= sin;
    end
  end

  // Stage 2: rotation matrix terms, column major.
  always_comb begin
    term_nxt[0] = tam_pkg::one_minus(yy_r, zz_r);
    term_nxt[1] = tam_pkg::twice_sum(xy_r, wz_r);
    term_nxt[2] = tam_pkg::twice_diff(xz_r, wy_r);
    term_nxt[3] = tam_pkg::twice_diff(xy_r, wz_r);
    term_nxt[4] = tam_pkg::one_minus(xx_r, zz_r);
    term_nxt[5] = tam_pkg::twice_sum(yz_r, wx_r);
    term_nxt[6] = tam_pkg::twice_sum(xz_r, wy_r);
    term_nxt[7] = tam_pkg::twice_diff(yz_r, wx_r);
    term_nxt[8] = tam_pkg::one_minus(xx_r, yy_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      term_r <= term_nxt;
      t2_r   <= t1_r;
      s2_r   <= s1_r;
    end
    if (rdy3) begin
      t3_r <= t2_r;
    end
    if (rdy4) begin
      t4_r <= t3_r;
    end
  end

  // Stages 3 and 4 live in the entry units.
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  for (genvar k = 0; k < tam_pkg::NumEnt; k++) begin : g_ent
    tam_scale_rnd u_ent (
      .clk   (clk),
      .en    (en),
      .term  (term_r[k]),
      .scale (s2_r[k / 3]),
      .q     (ent[k])
    );
  end

  always_comb begin
    for (int k = 0; k < tam_pkg::NumEnt; k++) begin
      out_tdata[32*k +: 32] = ent[k];
    end
    for (int k = 0; k < 3; k++) begin
      out_tdata[288 + 32*k +: 32] = t4_r[k];
    end
  end

  assign in_tready  = rdy1;
  assign out_tvalid = v4_r;

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("input stalled with a bubble in the pipeline");

  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> v4_r)
    else $error("item lost between stage 3 and output");

  a_trans_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> (out_tdata[383:288] == {$past(t3_r[2]), $past(t3_r[1]), $past(t3_r[0])}))
    else $error("translation out of step with matrix");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy2) |=> v2_r)
    else $error("stalled stage 2 item dropped");
`endif

endmodule

>>> sv/tam_scale_rnd.sv
// One matrix entry: multiply by axis scale, then round to Q10.22 and saturate.
module tam_scale_rnd (
  input  logic               clk,
  input  tam_pkg::stage_en_t en,
  input  tam_pkg::term_t     term,
  input  tam_pkg::scale_t    scale,
  output tam_pkg::entry_t    q
);

  localparam int unsigned ShW = tam_pkg::WideW + 1 - tam_pkg::RndSh;

  tam_pkg::wide_t  prod_nxt;
  tam_pkg::wide_t  prod_r;
  logic signed [tam_pkg::WideW:0] rnd;
  logic signed [ShW-1:0]          shr;
  tam_pkg::entry_t q_nxt;
  tam_pkg::entry_t q_r;

  assign prod_nxt = tam_pkg::wide_t'(term) * tam_pkg::wide_t'(scale);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod_r <= prod_nxt;
    end
    if (en.s4) begin
      q_r <= q_nxt;
    end
  end

  // Round half toward plus infinity, floor shift, clamp to 32 bits.
  always_comb begin
    rnd = (tam_pkg::WideW + 1)'(prod_r) + ((tam_pkg::WideW + 1)'(1) <<< (tam_pkg::RndSh - 1));
    shr = ShW'(rnd >>> tam_pkg::RndSh);
    if (shr[ShW-1:tam_pkg::EntryW-1] == '0 || shr[ShW-1:tam_pkg::EntryW-1] == '1) begin
      q_nxt = shr[tam_pkg::EntryW-1:0];
    end else if (shr[ShW-1]) begin
      q_nxt = {1'b1, {(tam_pkg::EntryW-1){1'b0}}};
    end else begin
      q_nxt = {1'b0, {(tam_pkg::EntryW-1){1'b1}}};
    end
  end

  assign q = q_r;

endmodule

>>> tb/sv/trs_to_affine_matrix_checker.sv
// Checker for the TRS to affine matrix block: predicts each result item and compares it.
module trs_to_affine_matrix_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [207:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [383:0] out_tdata,
  output int           fail_count,
  output int           matrices_pending,
  output int           matrices_checked
);

  localparam int NumFields = 12;

  string field_name [NumFields] = '{"m_c0r0", "m_c0r1", "m_c0r2", "m_c1r0", "m_c1r1",
                                    "m_c1r2", "m_c2r0", "m_c2r1", "m_c2r2",
                                    "out_tx", "out_ty", "out_tz"};

  logic [383:0] expected_mats [$];
  int           mismatches;

  // Q.36 to Q10.22: round half up, then clamp to 32 bits.
  function automatic tam_pkg::entry_t round_q22(longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return tam_pkg::entry_t'(r);
  endfunction

  function automatic logic [383:0] affine_of_trs(logic [207:0] d);
    longint x, y, z, w, sx, sy, sz;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
    tam_pkg::entry_t m [tam_pkg::NumEnt];
    one = 64'sd1 <<< 28;
    x  = longint'(tam_pkg::quat_t'(d[111:96]));
    y  = longint'(tam_pkg::quat_t'(d[127:112]));
    z  = longint'(tam_pkg::quat_t'(d[143:128]));
    w  = longint'(tam_pkg::quat_t'(d[159:144]));
    sx = longint'(tam_pkg::scale_t'(d[175:160]));
    sy = longint'(tam_pkg::scale_t'(d[191:176]));
    sz = longint'(tam_pkg::scale_t'(d[207:192]));
    xx = x * x; yy = y * y; zz = z * z;
    xy = x * y; xz = x * z; yz = y * z;
    wx = w * x; wy = w * y; wz = w * z;
    m[0] = round_q22((one - 2 * (yy + zz)) * sx);
    m[1] = round_q22((2 * (xy + wz)) * sx);
    m[2] = round_q22((2 * (xz - wy)) * sx);
    m[3] = round_q22((2 * (xy - wz)) * sy);
    m[4] = round_q22((one - 2 * (xx + zz)) * sy);
    m[5] = round_q22((2 * (yz + wx)) * sy);
    m[6] = round_q22((2 * (xz + wy)) * sz);
    m[7] = round_q22((2 * (yz - wx)) * sz);
    m[8] = round_q22((one - 2 * (xx + yy)) * sz);
    return {d[95:0], m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
  endfunction

  always @(posedge clk) begin
    logic [383:0] want;
    if (!rst_n) begin
      expected_mats.delete();
      fail_count = 0;
      matrices_pending = 0;
      matrices_checked = 0;
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready) expected_mats.push_back(affine_of_trs(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_mats.size() == 0) begin
          fail_count = fail_count + 1;
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("result item with nothing expected: %h", out_tdata);
        end else begin
          want = expected_mats.pop_front();
          matrices_checked = matrices_checked + 1;
          for (int i = 0; i < NumFields; i++) begin
            if (out_tdata[i*32 +: 32] !== want[i*32 +: 32]) begin
              fail_count = fail_count + 1;
              mismatches = mismatches + 1;
              if (mismatches <= 10)
                $display("result %0d %s: expected %0d, got %0d", matrices_checked,
                         field_name[i], $signed(want[i*32 +: 32]),
                         $signed(out_tdata[i*32 +: 32]));
            end
          end
        end
      end
      matrices_pending = expected_mats.size();
    end
  end

endmodule

>>> tb/sv/trs_to_affine_matrix_top_test.sv
// Testbench top for the TRS to affine matrix block: stimulus, flow control and verdict.
module trs_to_affine_matrix_top_test;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [207:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [383:0] out_tdata;

  int fail_count;
  int matrices_pending;
  int matrices_checked;
  int items_sent;
  int stall_left;
  bit calm;

  trs_to_affine_matrix_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  trs_to_affine_matrix_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .matrices_pending(matrices_pending),
    .matrices_checked(matrices_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [207:0] pack_xform(
      tam_pkg::trans_t tx, tam_pkg::trans_t ty, tam_pkg::trans_t tz,
      tam_pkg::quat_t qx, tam_pkg::quat_t qy, tam_pkg::quat_t qz, tam_pkg::quat_t qw,
      tam_pkg::scale_t sx, tam_pkg::scale_t sy, tam_pkg::scale_t sz);
    return {sz, sy, sx, qw, qz, qy, qx, tz, ty, tx};
  endfunction

  task automatic send_xform(logic [207:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    items_sent = items_sent + 1;
  endtask

  function automatic tam_pkg::quat_t rand_quat_full();
    return tam_pkg::quat_t'($urandom_range(0, 65535));
  endfunction

  function automatic tam_pkg::quat_t rand_quat_unit_range();
    return tam_pkg::quat_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic tam_pkg::scale_t rand_scale();
    if ($urandom_range(0, 1) == 0)
      return tam_pkg::scale_t'(int'($urandom_range(0, 4096)) - 2048);
    return tam_pkg::scale_t'($urandom_range(0, 65535));
  endfunction

  // Receiver: random stalls except in calm stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_tready <= 1'b0;
    end else if (calm) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int   kind;
    int   ax, ay, az, sum, aw;
    tam_pkg::quat_t qx, qy, qz, qw;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    calm       = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity, axis flips, extremes, saturation, rounding ties.
    send_xform(pack_xform(0, 0, 0, 0, 0, 0, 16384, 256, 256, 256));
    send_xform(pack_xform(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          0, 0, 0, 16384, 32767, 32767, 32767));
    send_xform(pack_xform(32'h80000000, 32'h80000000, 32'h80000000,
                          0, 0, 0, -16384, -32768, -32768, -32768));
    send_xform(pack_xform(1, -1, 2, 16384, 0, 0, 0, 256, 256, 256));
    send_xform(pack_xform(3, 4, 5, 0, 16384, 0, 0, 256, 512, -256));
    send_xform(pack_xform(-7, 8, -9, 0, 0, 16384, 0, -256, 256, 1024));
    send_xform(pack_xform(0, 0, 0, -16384, -16384, -16384, -16384, 256, 256, 256));
    send_xform(pack_xform(0, 0, 0, 8192, 8192, 8192, 8192, 256, 256, 256));
    send_xform(pack_xform(0, 0, 0, -32768, -32768, -32768, -32768, 32767, 32767, 32767));
    send_xform(pack_xform(0, 0, 0, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
    send_xform(pack_xform(32'h5555aaaa, 32'haaaa5555, 32'hffffffff,
                          32767, -32768, 32767, -32768, 32767, -32768, 1));
    send_xform(pack_xform(0, 0, 0, -32768, 32767, -32768, 32767, -1, 32767, -32768));
    send_xform(pack_xform(0, 0, 0, 0, 0, 0, 0, 256, 256, 256));
    send_xform(pack_xform(10, 20, 30, 8192, -8192, 8192, -8192, 0, 0, 0));
    // Exact halfway cases for rounding, positive and negative.
    send_xform(pack_xform(0, 0, 0, 0, 64, 0, 0, 1, 1, 1));
    send_xform(pack_xform(0, 0, 0, 0, 64, 0, 0, -1, -1, -1));
    send_xform(pack_xform(0, 0, 0, 64, 64, 64, 0, 3, -3, 5));
    send_xform(pack_xform(0, 0, 0, 1, -1, 1, 16383, 1, -1, 32767));

    for (int n = 0; n < 1350; n++) begin
      // Every third stretch of 150 items is calm, with no input gaps or output stalls.
      calm = ((n / 150) % 3) == 2;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // Near-unit quaternion: pick x, y, z and solve for w.
        ax  = int'($urandom_range(0, 18000)) - 9000;
        ay  = int'($urandom_range(0, 18000)) - 9000;
        az  = int'($urandom_range(0, 18000)) - 9000;
        sum = ax * ax + ay * ay + az * az;
        aw  = int'($sqrt(268435456.0 - real'(sum)));
        if ($urandom_range(0, 1) == 1) aw = -aw;
        qx = tam_pkg::quat_t'(ax); qy = tam_pkg::quat_t'(ay);
        qz = tam_pkg::quat_t'(az); qw = tam_pkg::quat_t'(aw);
      end else if (kind < 85) begin
        qx = rand_quat_full(); qy = rand_quat_full();
        qz = rand_quat_full(); qw = rand_quat_full();
      end else begin
        qx = rand_quat_unit_range(); qy = rand_quat_unit_range();
        qz = rand_quat_unit_range(); qw = rand_quat_unit_range();
      end
      send_xform(pack_xform(tam_pkg::trans_t'($urandom), tam_pkg::trans_t'($urandom),
                            tam_pkg::trans_t'($urandom),
                            qx, qy, qz, qw, rand_scale(), rand_scale(), rand_scale()));
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    calm = 1'b1;

    while (matrices_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d transforms (directed extremes, rounding ties, random quaternions)",
             items_sent);
    $display("checked %0d result matrices under random input gaps and output stalls",
             matrices_checked);
    if (fail_count == 0 && matrices_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
